// ===== rtl/core/ctb_pkg.sv =====
package ctb_pkg;

  localparam int CAPACITY   = 4096;
  localparam int SHOW_CHARS = 10;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SHOW_W     = $clog2(SHOW_CHARS + 1);
  localparam int CHAR_W     = 8;

  localparam logic [CNT_W-1:0]  CAPACITY_C = CNT_W'(CAPACITY);
  localparam logic [SHOW_W-1:0] SHOW_C     = SHOW_W'(SHOW_CHARS);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LEFT   = 2'd2,
    ACT_RIGHT  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_CHAR   = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DROP,
    OP_DELETE,
    OP_LEFT,
    OP_RIGHT
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_ACK,
    ST_MOVE,
    ST_SHOW_RD,
    ST_SHOW_OUT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  cur_old;
    logic [CNT_W-1:0]  rstart;
    logic [CNT_W-1:0]  cur_new;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cursor;
    logic [CNT_W-1:0] length;
  } front_stat_t;

endpackage

// ===== rtl/core/ctb_ram.sv =====
module ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ctb_queue.sv =====
module ctb_queue
  import ctb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  cmd_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rptr_r];
  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;

endmodule

// ===== rtl/core/ctb_front.sv =====
module ctb_front
  import ctb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [CHAR_W-1:0] in_ch,
  input  logic [CNT_W-1:0]  in_amount,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_data,
  output front_stat_t       stat
);

  logic [CNT_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] right;
  logic [CNT_W-1:0] m_left;
  logic [CNT_W-1:0] m_right;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // shadow cursor and length track where the back end will be
  always_comb begin
    right   = len_r - cur_r;
    m_left  = (in_amount < cur_r) ? in_amount : cur_r;
    m_right = (in_amount < right) ? in_amount : right;
    cur_nxt = cur_r;
    len_nxt = len_r;
    q_data.op      = OP_DROP;
    q_data.ch      = in_ch;
    q_data.count   = '0;
    q_data.cur_old = cur_r;
    q_data.rstart  = CAPACITY_C - right;
    unique case (act_t'(in_action))
      ACT_INSERT: begin
        if (len_r < CAPACITY_C) begin
          q_data.op = OP_INSERT;
          cur_nxt   = cur_r + 1'b1;
          len_nxt   = len_r + 1'b1;
        end
      end
      ACT_DELETE: begin
        q_data.op    = OP_DELETE;
        q_data.count = m_left;
        cur_nxt      = cur_r - m_left;
        len_nxt      = len_r - m_left;
      end
      ACT_LEFT: begin
        q_data.op    = OP_LEFT;
        q_data.count = m_left;
        cur_nxt      = cur_r - m_left;
      end
      ACT_RIGHT: begin
        q_data.op    = OP_RIGHT;
        q_data.count = m_right;
        cur_nxt      = cur_r + m_right;
      end
      default: ;
    endcase
    q_data.cur_new = cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      len_r <= '0;
    end else if (q_push) begin
      cur_r <= cur_nxt;
      len_r <= len_nxt;
    end
  end

  assign stat.cursor = cur_r;
  assign stat.length = len_r;

endmodule

// ===== rtl/core/ctb_back.sv =====
module ctb_back
  import ctb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_result_kind,
  output logic              out_full_dropped,
  output logic [CNT_W-1:0]  out_removed,
  output logic [CHAR_W-1:0] out_text_char,
  output logic              out_last
);

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [CNT_W-1:0]  mv_idx_r;
  logic              pend_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic [SHOW_W-1:0] sidx_r;

  logic              out_valid_r;
  kind_t             kind_r;
  logic              drop_r;
  logic [CNT_W-1:0]  removed_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;

  logic              can_load;
  logic              issue;
  logic [CNT_W-1:0]  src, dst;
  logic [SHOW_W-1:0] show_n;
  logic [CNT_W-1:0]  show_addr;
  logic              show_end;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CHAR_W-1:0] wdata, rdata;

  logic              ld;
  kind_t             ld_kind;
  logic              ld_drop;
  logic              ld_last;
  logic              ld_char_sel;

  ctb_ram #(.WIDTH(CHAR_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign can_load = !out_valid_r || !out_stall;
  assign issue    = mv_idx_r != cmd_r.count;

  // left of cursor sits at the bottom, right text at the top of the store
  always_comb begin
    if (cmd_r.op == OP_LEFT) begin
      src = cmd_r.cur_old - 1'b1 - mv_idx_r;
      dst = cmd_r.rstart - 1'b1 - mv_idx_r;
    end else begin
      src = cmd_r.rstart + mv_idx_r;
      dst = cmd_r.cur_old + mv_idx_r;
    end
    show_n    = (cmd_r.cur_new > CNT_W'(SHOW_CHARS)) ? SHOW_C
                                                      : cmd_r.cur_new[SHOW_W-1:0];
    show_addr = cmd_r.cur_new - CNT_W'(show_n) + CNT_W'(sidx_r);
    show_end  = (sidx_r + 1'b1) == show_n;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_data.op)
            OP_INSERT:         state_nxt = ST_WRITE;
            OP_LEFT, OP_RIGHT: state_nxt = ST_MOVE;
            default:           state_nxt = ST_ACK;
          endcase
        end
      end
      ST_WRITE:   state_nxt = ST_ACK;
      ST_ACK:     if (can_load) state_nxt = ST_IDLE;
      ST_MOVE:    if (!issue && !pend_r) state_nxt = ST_SHOW_RD;
      ST_SHOW_RD: begin
        if (show_n == '0) begin
          if (can_load) state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SHOW_OUT;
        end
      end
      ST_SHOW_OUT: begin
        if (can_load) state_nxt = show_end ? ST_IDLE : ST_SHOW_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    we          = 1'b0;
    waddr       = pend_addr_r;
    wdata       = rdata;
    re          = 1'b0;
    raddr       = src[ADDR_W-1:0];
    ld          = 1'b0;
    ld_kind     = KIND_INSERT;
    ld_drop     = 1'b0;
    ld_last     = 1'b1;
    ld_char_sel = 1'b0;
    unique case (state_r)
      ST_IDLE:  q_pop = !q_empty;
      ST_WRITE: begin
        we    = 1'b1;
        waddr = cmd_r.cur_old[ADDR_W-1:0];
        wdata = cmd_r.ch;
      end
      ST_ACK: begin
        ld      = can_load;
        ld_kind = (cmd_r.op == OP_DELETE) ? KIND_DELETE : KIND_INSERT;
        ld_drop = cmd_r.op == OP_DROP;
      end
      ST_MOVE: begin
        re = issue;
        we = pend_r;
      end
      ST_SHOW_RD: begin
        if (show_n == '0) begin
          ld      = can_load;
          ld_kind = KIND_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = show_addr[ADDR_W-1:0];
        end
      end
      ST_SHOW_OUT: begin
        ld          = can_load;
        ld_kind     = KIND_CHAR;
        ld_last     = show_end;
        ld_char_sel = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_IDLE) begin
        pend_r <= 1'b0;
      end else if (state_r == ST_MOVE) begin
        pend_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r    <= q_data;
      mv_idx_r <= '0;
      sidx_r   <= '0;
    end
    if (state_r == ST_MOVE && issue) begin
      mv_idx_r    <= mv_idx_r + 1'b1;
      pend_addr_r <= dst[ADDR_W-1:0];
    end
    if (state_r == ST_SHOW_OUT && can_load) begin
      sidx_r <= sidx_r + 1'b1;
    end
    if (ld) begin
      kind_r    <= ld_kind;
      drop_r    <= ld_drop;
      removed_r <= (ld_kind == KIND_DELETE) ? cmd_r.count : '0;
      char_r    <= ld_char_sel ? rdata : '0;
      last_r    <= ld_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_full_dropped = drop_r;
  assign out_removed      = removed_r;
  assign out_text_char    = char_r;
  assign out_last         = last_r;

endmodule

// ===== rtl/core/cursor_text_buffer.sv =====
// an insert writes its character and then reports; a delete or a dropped insert goes straight to its report;
// a cursor move by m places copies m characters, then each shown char is read and then output,
// or an empty text marker instead; the back end pops the next command when it returns to idle;
// the single-port-write text store moves one character across the gap per cycle
// a two-entry command queue lets new items be classified while the back end works
// reset clears cursor, length, queue and control state; the text store is not cleared
module cursor_text_buffer
  import ctb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [CHAR_W-1:0] in_ch,
  input  logic [CNT_W-1:0]  in_amount,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_result_kind,
  output logic              out_full_dropped,
  output logic [CNT_W-1:0]  out_removed,
  output logic [CHAR_W-1:0] out_text_char,
  output logic              out_last
);

  logic        q_push, q_pop, q_full, q_empty;
  cmd_t        q_in, q_out;
  front_stat_t stat;

  ctb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_ch     (in_ch),
    .in_amount (in_amount),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in),
    .stat      (stat)
  );

  ctb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  ctb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_out),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_full_dropped (out_full_dropped),
    .out_removed      (out_removed),
    .out_text_char    (out_text_char),
    .out_last         (out_last)
  );

  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    stat.cursor <= stat.length)
    else $error("cursor beyond text length");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.length <= CAPACITY_C)
    else $error("text length beyond capacity");

  a_full_drop_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action == ACT_INSERT && stat.length == CAPACITY_C)
    |=> $stable(stat.length) && $stable(stat.cursor))
    else $error("dropped insert changed the text");

endmodule
